// ----- rtl/bmp24_to_rgb565_streamer_top_macros.svh -----
// Assertion helpers for the RTL files; the queue is the one that includes them.
`ifndef BMP24_TO_RGB565_STREAMER_TOP_MACROS_SVH
`define BMP24_TO_RGB565_STREAMER_TOP_MACROS_SVH

// Checked on every clk edge outside of reset.
`define BMP565_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define BMP565_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bmp565_pkg.sv -----
package bmp565_pkg;

  localparam int HEADER_BYTES = 54;
  localparam logic [31:0] HDR_LAST     = 32'(HEADER_BYTES - 1);
  localparam logic [31:0] HDR_BYTES_32 = 32'(HEADER_BYTES);

  // header field byte positions (little endian)
  localparam logic [31:0] POS_OFFSET_LO = 32'd10;
  localparam logic [31:0] POS_OFFSET_HI = 32'd13;
  localparam logic [31:0] POS_WIDTH_LO  = 32'd18;
  localparam logic [31:0] POS_WIDTH_HI  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_LO = 32'd22;
  localparam logic [31:0] POS_HEIGHT_HI = 32'd25;
  localparam logic [31:0] POS_DEPTH_LO  = 32'd28;
  localparam logic [31:0] POS_DEPTH_HI  = 32'd29;

  localparam logic [15:0] DEPTH_24 = 16'd24;

  localparam logic [7:0] RED_MASK   = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;

  // queue between parser and formatter; depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP     = 2'd2;

  localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd240;
  localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd135;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DEPTH = 2'd1,
    KIND_SIZE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic        byte_swap;
  } cfg_t;

  // one result as handed from parser to formatter
  typedef struct packed {
    kind_t       kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [4:0]  red;
    logic [5:0]  green;
    logic [4:0]  blue;
    logic        last;
  } item_t;

  function automatic logic [15:0] pack_color(input item_t it, input logic swap);
    logic [15:0] c;
    c = {it.red, it.green, it.blue};
    return swap ? {c[7:0], c[15:8]} : c;
  endfunction

endpackage

// ----- rtl/bmp24_to_rgb565_streamer_top.sv -----
// BMP 24-bit to RGB565 streamer. Feed a BMP file one byte per transaction on
// the s_axis side, with s_axis_tuser[0] set on the first byte of each file to
// restart parsing (after reset the stream is parsed as a file from byte 0).
// The 54-byte header supplies the data offset, width, height and depth; bytes
// up to the data offset are dropped, then bottom-up B,G,R rows are read and
// the row padding to four bytes is discarded. Each pixel of a row that fits
// the screen (y < screen_height, width <= screen_width) leaves on m_axis as
// one transaction with x, y and RGB565 color (byte-swapped when byte_swap is
// set); tlast marks the pixel at the end of row 0. A depth other than 24 gives
// one kind 1 result, a width or height above 65535 one kind 2 result; error
// results carry zero data. Rate: one byte per clock while the queue is not
// full. The parser settles each byte combinationally, and a result reaches
// m_axis through the four-deep queue and then the output register, so
// s_axis_tready drops only once the queue fills while m_axis is stalled.
// No clearing pass after reset. Registers (cfg_index): 0 screen_width,
// 1 screen_height, 2 byte_swap; write them only while the block is idle.
module bmp24_to_rgb565_streamer_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [bmp565_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmp565_pkg::CFG_DATA_W-1:0] cfg_data,
  // byte input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] byte_value
  input  logic [0:0]                        s_axis_tuser,  // [0] first_byte
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // [15:0] pixel_x, [31:16] pixel_y,
                                                           // [47:32] color
  output logic [1:0]                        m_axis_tuser,  // [1:0] kind
  output logic                              m_axis_tlast   // last
);

  bmp565_pkg::cfg_t  cfg;
  bmp565_pkg::item_t push_item, q_item;
  logic              push, pop, q_valid, q_full;

  // configuration registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= bmp565_pkg::RST_SCREEN_WIDTH;
      cfg.screen_height <= bmp565_pkg::RST_SCREEN_HEIGHT;
      cfg.byte_swap     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bmp565_pkg::CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        bmp565_pkg::CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        bmp565_pkg::CFG_BYTE_SWAP:     cfg.byte_swap     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // parser: header capture, skip, pixel/padding tracking, clipping
  bmp565_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .byte_value (s_axis_tdata),
    .first_byte (s_axis_tuser[0]),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  bmp565_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  // formatter: RGB565 packing, optional swap, output register
  bmp565_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- rtl/bmp565_front.sv -----
module bmp565_front (
  input  logic                clk,
  input  logic                rst,
  input  bmp565_pkg::cfg_t    cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          byte_value,
  input  logic                first_byte,
  input  logic                q_full,
  output logic                push,
  output bmp565_pkg::item_t   push_item
);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXEL  = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  phase_t      phase, phase_next, c_phase;
  logic [31:0] byte_pos, byte_pos_next, c_pos;
  logic [31:0] data_off, data_off_next, c_off;
  logic [31:0] img_w, img_w_next, c_w;
  logic [31:0] img_h, img_h_next, c_h;
  logic [15:0] bit_depth, bit_depth_next, c_depth;
  logic [15:0] column, column_next, c_col;
  logic [15:0] row, row_next, c_row;
  logic [1:0]  pad_left, pad_left_next, c_pad;
  logic [1:0]  chan, chan_next, c_chan;
  logic [7:0]  blue, blue_next;
  logic [7:0]  green, green_next;
  logic [1:0]  lane;
  logic        eor;
  logic        res_valid;
  logic        accept;
  logic [16:0] col_inc;
  bmp565_pkg::item_t res;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && res_valid;
  assign push_item = res;

  // a first byte restarts parsing from the cleared state
  always_comb begin
    c_phase = first_byte ? PH_HEADER : phase;
    c_pos   = first_byte ? '0 : byte_pos;
    c_off   = first_byte ? '0 : data_off;
    c_w     = first_byte ? '0 : img_w;
    c_h     = first_byte ? '0 : img_h;
    c_depth = first_byte ? '0 : bit_depth;
    c_col   = first_byte ? '0 : column;
    c_row   = first_byte ? '0 : row;
    c_pad   = first_byte ? '0 : pad_left;
    c_chan  = first_byte ? '0 : chan;
  end

  always_comb begin
    phase_next     = c_phase;
    data_off_next  = c_off;
    img_w_next     = c_w;
    img_h_next     = c_h;
    bit_depth_next = c_depth;
    column_next    = c_col;
    row_next       = c_row;
    pad_left_next  = c_pad;
    chan_next      = c_chan;
    blue_next      = blue;
    green_next     = green;
    eor            = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    col_inc        = {1'b0, c_col} + 17'd1;
    // header lanes start at positions that are 2 mod 4
    lane           = c_pos[1:0] - 2'd2;

    if ((c_phase != PH_DONE) && (c_pos != '1)) begin
      byte_pos_next = c_pos + 32'd1;
    end else begin
      byte_pos_next = c_pos;
    end

    case (c_phase)
      PH_HEADER: begin
        if (c_pos >= bmp565_pkg::POS_OFFSET_LO && c_pos <= bmp565_pkg::POS_OFFSET_HI) begin
          data_off_next[{lane, 3'b000} +: 8] = byte_value;
        end else if (c_pos >= bmp565_pkg::POS_WIDTH_LO &&
                     c_pos <= bmp565_pkg::POS_WIDTH_HI) begin
          img_w_next[{lane, 3'b000} +: 8] = byte_value;
        end else if (c_pos >= bmp565_pkg::POS_HEIGHT_LO &&
                     c_pos <= bmp565_pkg::POS_HEIGHT_HI) begin
          img_h_next[{lane, 3'b000} +: 8] = byte_value;
        end else if (c_pos == bmp565_pkg::POS_DEPTH_LO) begin
          bit_depth_next[7:0] = byte_value;
        end else if (c_pos == bmp565_pkg::POS_DEPTH_HI) begin
          bit_depth_next[15:8] = byte_value;
        end
        if (c_pos == bmp565_pkg::HDR_LAST) begin
          if (c_depth != bmp565_pkg::DEPTH_24) begin
            res_valid  = 1'b1;
            res.kind   = bmp565_pkg::KIND_DEPTH;
            phase_next = PH_DONE;
          end else if (c_w[31:16] != '0 || c_h[31:16] != '0) begin
            res_valid  = 1'b1;
            res.kind   = bmp565_pkg::KIND_SIZE;
            phase_next = PH_DONE;
          end else if (c_w == '0 || c_h == '0) begin
            phase_next = PH_DONE;
          end else begin
            if (c_off < bmp565_pkg::HDR_BYTES_32) begin
              data_off_next = bmp565_pkg::HDR_BYTES_32;
            end
            row_next    = c_h[15:0] - 16'd1;
            column_next = '0;
            chan_next   = '0;
            phase_next  = (c_off <= bmp565_pkg::HDR_BYTES_32) ? PH_PIXEL : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (c_pos >= c_off - 32'd1) begin
          phase_next = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        case (c_chan)
          2'd0: begin
            blue_next = byte_value;
            chan_next = 2'd1;
          end
          2'd1: begin
            green_next = byte_value;
            chan_next  = 2'd2;
          end
          default: begin
            chan_next = 2'd0;
            if (c_row < {4'b0, cfg.screen_height} && c_w <= {20'b0, cfg.screen_width}) begin
              res_valid = 1'b1;
              res.kind  = bmp565_pkg::KIND_PIXEL;
              res.x     = c_col;
              res.y     = c_row;
              res.red   = byte_value[7:3];
              res.green = green[7:2];
              res.blue  = blue[7:3];
              res.last  = (c_row == '0) && (col_inc == c_w[16:0]);
            end
            column_next = col_inc[15:0];
            if (col_inc[15:0] == c_w[15:0]) begin
              pad_left_next = c_w[1:0];
              if (c_w[1:0] != '0) begin
                phase_next = PH_PAD;
              end else begin
                eor = 1'b1;
              end
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_left_next = c_pad - 2'd1;
        if (pad_left_next == '0) begin
          eor = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (eor) begin
      if (c_row == '0) begin
        phase_next = PH_DONE;
      end else begin
        row_next    = c_row - 16'd1;
        column_next = '0;
        chan_next   = '0;
        phase_next  = PH_PIXEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      byte_pos  <= '0;
      data_off  <= '0;
      img_w     <= '0;
      img_h     <= '0;
      bit_depth <= '0;
      column    <= '0;
      row       <= '0;
      pad_left  <= '0;
      chan      <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      byte_pos  <= byte_pos_next;
      data_off  <= data_off_next;
      img_w     <= img_w_next;
      img_h     <= img_h_next;
      bit_depth <= bit_depth_next;
      column    <= column_next;
      row       <= row_next;
      pad_left  <= pad_left_next;
      chan      <= chan_next;
    end
  end

  // pixel bytes held until the red byte completes the triplet
  always_ff @(posedge clk) begin
    if (accept) begin
      blue  <= blue_next;
      green <= green_next;
    end
  end

endmodule

// ----- rtl/bmp565_queue.sv -----
`include "bmp24_to_rgb565_streamer_top_macros.svh"

module bmp565_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bmp565_pkg::item_t  push_item,
  input  logic               pop,
  output logic               q_valid,
  output logic               q_full,
  output bmp565_pkg::item_t  q_item
);

  localparam logic [bmp565_pkg::QCNT_W-1:0] DEPTH_CNT =
    bmp565_pkg::QCNT_W'(bmp565_pkg::QUEUE_DEPTH);

  bmp565_pkg::item_t mem [bmp565_pkg::QUEUE_DEPTH];
  logic [bmp565_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [bmp565_pkg::QCNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == DEPTH_CNT);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers wrap naturally: depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `BMP565_ASSERT(a_count_bound, count <= DEPTH_CNT, "queue count overflow")
  `BMP565_ASSERT(a_push_grows, (push && !pop) |=> (count == $past(count) + 1'b1), "push lost")
  `BMP565_ASSERT(a_pop_nonempty, pop |-> (count != '0), "pop from empty queue")
  `BMP565_ASSERT_NORST(a_reset_empty, rst |=> (count == '0), "queue not empty after reset")

endmodule

// ----- rtl/bmp565_back.sv -----
module bmp565_back (
  input  logic               clk,
  input  logic               rst,
  input  bmp565_pkg::cfg_t   cfg,
  input  logic               q_valid,
  input  bmp565_pkg::item_t  q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        out_data,
  output logic [1:0]         out_user,
  output logic               out_last
);

  // output register refills in the cycle it is taken
  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {bmp565_pkg::pack_color(q_item, cfg.byte_swap), q_item.y, q_item.x};
      out_user <= q_item.kind;
      out_last <= q_item.last;
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Testbench for bmp24_to_rgb565_streamer_top.
// BMP files are built in the bench and streamed one byte per transaction.
// A software copy of the parser runs on every accepted byte and queues the
// pixel or error it expects. A checker pops that queue on every accepted
// output transaction and compares all fields.
module tb;

  localparam int HDR_LEN     = 54;    // BMP header length
  localparam int OFF_POS     = 10;    // data offset, 4 bytes LE
  localparam int WID_POS     = 18;    // width, 4 bytes LE
  localparam int HGT_POS     = 22;    // height, 4 bytes LE
  localparam int DEP_POS     = 28;    // bit depth, 2 bytes LE
  localparam logic [15:0] BMP_DEPTH = 16'd24;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int STALL_LIMIT = 4000;  // cycles with no transaction at all
  localparam int ITEM_GOAL   = 1850;  // bytes the whole run sends at least
  localparam int SETTLE      = 8;     // parser + queue + output register
  localparam int MAX_REPORTS = 20;

  typedef enum logic [4:0] {
    P_HEADER = 5'b00001,
    P_SKIP   = 5'b00010,
    P_PIXEL  = 5'b00100,
    P_PAD    = 5'b01000,
    P_DONE   = 5'b10000
  } parse_phase_t;

  typedef struct packed {
    bmp565_pkg::kind_t kind;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [15:0]       color;
    logic              tail;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst;

  logic                              cfg_we;
  logic [bmp565_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bmp565_pkg::CFG_DATA_W-1:0] cfg_data;

  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_value
  logic [0:0]  s_axis_tuser;   // [0] first_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [15:0] pixel_x, [31:16] pixel_y, [47:32] color
  logic [1:0]  m_axis_tuser;   // [1:0] kind
  logic        m_axis_tlast;

  always #10 clk = ~clk;

  bmp24_to_rgb565_streamer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------
  // Parser shadow: screen settings and parse state of the block.
  // ---------------------------------------------------------------------
  logic [11:0]  scr_w;
  logic [11:0]  scr_h;
  logic         swap_en;

  logic [31:0]  pos_q;
  logic [31:0]  off_q;
  logic [31:0]  wid_q;
  logic [31:0]  hgt_q;
  logic [15:0]  depth_q;
  logic [15:0]  col_q;
  logic [15:0]  row_q;
  logic [1:0]   pad_q;
  logic [1:0]   chan_q;
  logic [15:0]  bg_q;     // green high byte, blue low byte
  parse_phase_t phase;

  pixel_result_t expected_pixels[$];
  logic [7:0]    file_q[$];

  int  errors      = 0;
  int  bytes_sent  = 0;
  int  files_sent  = 0;
  int  checked     = 0;
  int  cfg_writes  = 0;
  int  burst_left  = 0;
  bit  hold_req    = 1'b0;

  function automatic void clear_parser();
    pos_q   = '0;
    off_q   = '0;
    wid_q   = '0;
    hgt_q   = '0;
    depth_q = '0;
    col_q   = '0;
    row_q   = '0;
    pad_q   = '0;
    chan_q  = '0;
    bg_q    = '0;
    phase   = P_HEADER;
  endfunction

  // Step the shadow parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic restart,
                                    output pixel_result_t res);
    logic [31:0] p;
    logic [15:0] c;
    bit          hit;
    hit = 1'b0;
    res = '{bmp565_pkg::KIND_PIXEL, 16'd0, 16'd0, 16'd0, 1'b0};
    if (restart) clear_parser();
    p = pos_q;
    if (phase != P_DONE && pos_q != '1) pos_q = pos_q + 32'd1;

    case (phase)
      P_HEADER: begin
        if (p >= OFF_POS && p < OFF_POS + 4) off_q[8*(p-OFF_POS) +: 8] = b;
        else if (p >= WID_POS && p < WID_POS + 4) wid_q[8*(p-WID_POS) +: 8] = b;
        else if (p >= HGT_POS && p < HGT_POS + 4) hgt_q[8*(p-HGT_POS) +: 8] = b;
        else if (p == DEP_POS) depth_q[7:0] = b;
        else if (p == DEP_POS + 1) depth_q[15:8] = b;
        if (p == HDR_LEN - 1) begin
          // depth is judged before size
          if (depth_q != BMP_DEPTH) begin
            res.kind = bmp565_pkg::KIND_DEPTH;
            hit = 1'b1;
            phase = P_DONE;
          end else if (wid_q > 32'hFFFF || hgt_q > 32'hFFFF) begin
            res.kind = bmp565_pkg::KIND_SIZE;
            hit = 1'b1;
            phase = P_DONE;
          end else if (wid_q == 0 || hgt_q == 0) begin
            phase = P_DONE;
          end else begin
            if (off_q < HDR_LEN) off_q = HDR_LEN;
            row_q  = 16'(hgt_q - 32'd1);
            col_q  = '0;
            chan_q = '0;
            phase  = (off_q == HDR_LEN) ? P_PIXEL : P_SKIP;
          end
        end
      end
      P_SKIP: begin
        if (p >= off_q - 32'd1) phase = P_PIXEL;
      end
      P_PIXEL: begin
        if (chan_q == 2'd0) begin
          bg_q[7:0] = b;
          chan_q = 2'd1;
        end else if (chan_q == 2'd1) begin
          bg_q[15:8] = b;
          chan_q = 2'd2;
        end else begin
          c = {b[7:3], bg_q[15:10], bg_q[7:3]};
          if (swap_en) c = {c[7:0], c[15:8]};
          chan_q = 2'd0;
          if (32'(row_q) < 32'(scr_h) && wid_q <= 32'(scr_w)) begin
            res.x     = col_q;
            res.y     = row_q;
            res.color = c;
            res.tail  = (row_q == 0) && (32'(col_q) + 32'd1 == wid_q);
            hit = 1'b1;
          end
          col_q = col_q + 16'd1;
          if (32'(col_q) == wid_q) begin
            pad_q = wid_q[1:0];
            if (pad_q != 0) phase = P_PAD;
            else if (row_q == 0) phase = P_DONE;
            else begin
              row_q = row_q - 16'd1;
              col_q = '0;
              phase = P_PIXEL;
            end
          end
        end
      end
      P_PAD: begin
        pad_q = pad_q - 2'd1;
        if (pad_q == 0) begin
          if (row_q == 0) phase = P_DONE;
          else begin
            row_q  = row_q - 16'd1;
            col_q  = '0;
            chan_q = '0;
            phase  = P_PIXEL;
          end
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps in between.
  // tvalid stays high across back-to-back bytes; it is only lowered at a
  // gap or by wait_idle.
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic restart);
    pixel_result_t res;
    int            gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= b;
    s_axis_tuser[0] <= restart;
    do @(posedge clk); while (!s_axis_tready);
    // transaction accepted at this edge
    bytes_sent++;
    if (parse_byte(b, restart, res)) expected_pixels.push_back(res);
  endtask

  task automatic send_file(input int count, input bit mark);
    for (int i = 0; i < count; i++) send_byte(file_q[i], mark && i == 0);
    files_sent++;
  endtask

  // Header with random filler, then optional skip gap, rows and padding.
  task automatic build_file(input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] off, input logic [15:0] depth,
                            input bit with_body);
    int n_skip;
    int n_pix;
    int sel;
    file_q.delete();
    for (int i = 0; i < HDR_LEN; i++) file_q.push_back(8'($urandom));
    for (int k = 0; k < 4; k++) begin
      file_q[OFF_POS + k] = off[8*k +: 8];
      file_q[WID_POS + k] = w[8*k +: 8];
      file_q[HGT_POS + k] = h[8*k +: 8];
    end
    file_q[DEP_POS]     = depth[7:0];
    file_q[DEP_POS + 1] = depth[15:8];
    if (with_body) begin
      n_skip = (off > HDR_LEN) ? int'(off) - HDR_LEN : 0;
      repeat (n_skip) file_q.push_back(8'($urandom));
      n_pix = int'(h) * (3 * int'(w) + int'(w[1:0]));
      for (int i = 0; i < n_pix; i++) begin
        sel = $urandom_range(0, 7);
        file_q.push_back(sel == 0 ? 8'h00 : (sel == 1 ? 8'hFF : 8'($urandom)));
      end
    end
  endtask

  // Drop tvalid, let every expected result drain, then let any byte that
  // causes no result clear the pipeline.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [bmp565_pkg::CFG_IDX_W-1:0] idx,
                         input logic [11:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
    case (idx)
      bmp565_pkg::CFG_SCREEN_WIDTH:  scr_w = val;
      bmp565_pkg::CFG_SCREEN_HEIGHT: scr_h = val;
      bmp565_pkg::CFG_BYTE_SWAP:     swap_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_screen(input logic [11:0] w, input logic [11:0] h, input logic swap);
    wait_idle();
    set_reg(bmp565_pkg::CFG_SCREEN_WIDTH, w);
    set_reg(bmp565_pkg::CFG_SCREEN_HEIGHT, h);
    set_reg(bmp565_pkg::CFG_BYTE_SWAP, {11'd0, swap});
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every accepted output transaction against the oldest
  // expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind  = bmp565_pkg::kind_t'(m_axis_tuser);
      got.x     = m_axis_tdata[15:0];
      got.y     = m_axis_tdata[31:16];
      got.color = m_axis_tdata[47:32];
      got.tail  = m_axis_tlast;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result kind=%0d x=%0d y=%0d color=%h last=%b",
                   $time, got.kind, got.x, got.y, got.color, got.tail);
      end else begin
        want = expected_pixels.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"%0t: mismatch expected kind=%0d x=%0d y=%0d color=%h last=%b",
                      " actual kind=%0d x=%0d y=%0d color=%h last=%b"},
                     $time, want.kind, want.x, want.y, want.color, want.tail,
                     got.kind, got.x, got.y, got.color, got.tail);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: tready pattern switches between full rate, random, periodic
  // and mostly-stalled spans. On request it holds off for HOLD_CYCLES so
  // the internal queue fills and s_axis_tready drops.
  // ---------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    int tick;
    m_axis_tready = 1'b0;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 120);
      end
      span--;
      tick++;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (tick % 4) != 3;
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: a quiet run that reaches STALL_LIMIT without a transaction on
  // either side is a hang.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, expected_pixels.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Right after reset the stream is a file from byte 0 even without the
  // restart flag; bytes after the image are ignored.
  task automatic test_unmarked_after_reset();
    build_file(32'd3, 32'd2, HDR_LEN, BMP_DEPTH, 1'b1);
    repeat (4) file_q.push_back(8'($urandom));
    send_file(file_q.size(), 1'b0);
  endtask

  // Header-only files: bad depth, depth beats size, width/height too big
  // (incl. a negative height), empty images.
  task automatic test_header_checks();
    logic [31:0] ws[6];
    logic [31:0] hs[6];
    logic [15:0] ds[6];
    ws = '{32'd5, 32'd70000, 32'h0001_0000, 32'd1, 32'd0, 32'd4};
    hs = '{32'd5, 32'd3, 32'd1, 32'hFFFF_FFFF, 32'd4, 32'd0};
    ds = '{16'd16, 16'd32, BMP_DEPTH, BMP_DEPTH, BMP_DEPTH, BMP_DEPTH};
    for (int i = 0; i < 6; i++) begin
      build_file(ws[i], hs[i], HDR_LEN, ds[i], 1'b0);
      repeat (3) file_q.push_back(8'($urandom));
      send_file(file_q.size(), 1'b1);
    end
  endtask

  // Offset below the header clamps to 54, larger offsets skip filler;
  // widths 1..4 cover every row padding.
  task automatic test_offsets_and_padding();
    build_file(32'd1, 32'd2, 32'd0, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    build_file(32'd2, 32'd2, 32'd55, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    build_file(32'd3, 32'd1, 32'd60, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    build_file(32'd4, 32'd2, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
  endtask

  // Screen extremes and clipping: rows at or above screen_height and
  // images wider than screen_width are consumed silently.
  task automatic test_screen_clipping();
    set_screen(12'd1, 12'd1, 1'b0);
    build_file(32'd1, 32'd3, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    build_file(32'd2, 32'd2, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    set_screen(12'd4095, 12'd4095, 1'b1);
    build_file(32'd5, 32'd2, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    set_screen(12'd4, 12'd2, 1'b0);
    build_file(32'd4, 32'd4, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    build_file(32'd5, 32'd1, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
    set_screen(12'd240, 12'd135, 1'b1);
  endtask

  // Restart flag cuts a file mid-header and mid-pixels.
  task automatic test_restart();
    build_file(32'd4, 32'd3, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(30, 1'b1);
    build_file(32'd3, 32'd3, 32'd56, BMP_DEPTH, 1'b1);
    send_file(HDR_LEN + 12, 1'b1);
    build_file(32'd2, 32'd2, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
  endtask

  // Long receiver hold-off while bytes keep coming: block must stall input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    build_file(32'd6, 32'd8, HDR_LEN, BMP_DEPTH, 1'b1);
    send_file(file_q.size(), 1'b1);
  endtask

  // Mostly well-formed files with random content, plus truncated files,
  // error headers, empty images and raw noise; screen settings change
  // every few files. Runs until the whole run reaches ITEM_GOAL bytes.
  task automatic test_random_files();
    int          sel;
    int          nfile;
    int          cut;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    logic [15:0] depth;
    nfile = 0;
    while (bytes_sent < ITEM_GOAL) begin
      if (nfile % 8 == 0) begin
        case ($urandom_range(0, 4))
          0: set_screen(12'd1, 12'd1, 1'($urandom));
          1: set_screen(12'd4095, 12'd4095, 1'($urandom));
          2: set_screen(12'($urandom_range(1, 8)), 12'($urandom_range(1, 6)), 1'($urandom));
          3: set_screen(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                        1'($urandom));
          default: set_screen(12'd240, 12'd135, 1'b1);
        endcase
      end
      nfile++;
      sel = $urandom_range(0, 9);
      if (sel <= 6 || sel == 9) begin
        w = $urandom_range(1, 7);
        h = $urandom_range(1, 5);
        case ($urandom_range(0, 5))
          0:       off = $urandom_range(0, HDR_LEN - 1);
          1:       off = $urandom_range(HDR_LEN + 1, HDR_LEN + 12);
          default: off = HDR_LEN;
        endcase
        build_file(w, h, off, BMP_DEPTH, 1'b1);
        if (sel == 9) cut = $urandom_range(1, HDR_LEN - 1);
        else if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, file_q.size() - 1);
        else cut = file_q.size();
        send_file(cut, $urandom_range(0, 15) != 0);
      end else if (sel == 7) begin
        w = $urandom;
        h = $urandom;
        case ($urandom_range(0, 2))
          0: depth = 16'($urandom);
          1: begin
            depth = BMP_DEPTH;
            if (w <= 32'hFFFF && h <= 32'hFFFF) h[$urandom_range(16, 31)] = 1'b1;
          end
          default: begin
            depth = BMP_DEPTH;
            if ($urandom_range(0, 1) != 0) begin
              w = 32'd0;
              h = $urandom_range(0, 9);
            end else begin
              w = $urandom_range(1, 9);
              h = 32'd0;
            end
          end
        endcase
        build_file(w, h, $urandom_range(0, 80), depth, 1'b0);
        repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom));
        send_file(file_q.size(), 1'b1);
      end else begin
        repeat ($urandom_range(8, 40)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    scr_w         = 12'd240;
    scr_h         = 12'd135;
    swap_en       = 1'b1;
    clear_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unmarked_after_reset();
    test_header_checks();
    test_offsets_and_padding();
    test_screen_clipping();
    test_restart();
    test_backpressure();
    test_random_files();

    wait_idle();
    $display("run: %0d bytes in %0d files, %0d results checked, %0d register writes",
             bytes_sent, files_sent, checked, cfg_writes);
    $display("run: header errors, offsets, padding, clipping, restarts, long stall, %0d errors",
             errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
